FILE: src/cc20_pkg.sv
// ---------------------------------------------------------------------------
// cc20_pkg: shared types, constants and state helpers
// Word and state types, the round count, the stage count and the helpers
// that build and reorder the sixteen-word ChaCha20 state.
// ---------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	// Each double round is four pipeline stages: two half quarter rounds on
	// the columns and two on the diagonals.
	localparam int NUM_STAGES = 4 * DOUBLE_ROUNDS;

	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 3;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0] widx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY01   = 3'd0,
		REG_KEY23   = 3'd1,
		REG_KEY45   = 3'd2,
		REG_KEY67   = 3'd3,
		REG_NONCE01 = 3'd4,
		REG_NONCE2  = 3'd5
	} cfg_reg_t;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam widx_t LAST_IDX = 4'd15;

	// Initial state: constants, key, block counter, nonce.
	function automatic state_t init_state(
		input logic [CFG_W-1:0] k01,
		input logic [CFG_W-1:0] k23,
		input logic [CFG_W-1:0] k45,
		input logic [CFG_W-1:0] k67,
		input logic [CFG_W-1:0] n01,
		input word_t n2,
		input word_t cnt
	);
		state_t s;
		s[0]  = SIGMA0;
		s[1]  = SIGMA1;
		s[2]  = SIGMA2;
		s[3]  = SIGMA3;
		s[4]  = k01[31:0];
		s[5]  = k01[63:32];
		s[6]  = k23[31:0];
		s[7]  = k23[63:32];
		s[8]  = k45[31:0];
		s[9]  = k45[63:32];
		s[10] = k67[31:0];
		s[11] = k67[63:32];
		s[12] = cnt;
		s[13] = n01[31:0];
		s[14] = n01[63:32];
		s[15] = n2;
		return s;
	endfunction

	// Rotate rows 1..3 left by 1..3 so that the diagonals line up as columns.
	function automatic state_t diagonalize(input state_t s);
		state_t r;
		for (int q = 0; q < 4; q++) begin
			r[q]      = s[q];
			r[4 + q]  = s[4 + ((q + 1) % 4)];
			r[8 + q]  = s[8 + ((q + 2) % 4)];
			r[12 + q] = s[12 + ((q + 3) % 4)];
		end
		return r;
	endfunction

	// Inverse of diagonalize.
	function automatic state_t undiagonalize(input state_t s);
		state_t r;
		for (int q = 0; q < 4; q++) begin
			r[q]                   = s[q];
			r[4 + ((q + 1) % 4)]   = s[4 + q];
			r[8 + ((q + 2) % 4)]   = s[8 + q];
			r[12 + ((q + 3) % 4)]  = s[12 + q];
		end
		return r;
	endfunction

endpackage

FILE: src/cc20_ifs.sv
// ---------------------------------------------------------------------------
// cc20_ifs: channel interfaces
// Valid/ready channels for the block counter input and the keystream output.
// ---------------------------------------------------------------------------
interface cc20_ctr_if;
	import cc20_pkg::*;

	logic  valid;
	logic  ready;
	word_t block_counter;

	modport source (output valid, output block_counter, input ready);
	modport sink (input valid, input block_counter, output ready);
endinterface

interface cc20_ks_if;
	import cc20_pkg::*;

	logic  valid;
	logic  ready;
	widx_t word_index;
	word_t keystream_word;
	logic  last_word;

	modport source (output valid, output word_index, output keystream_word,
		output last_word, input ready);
	modport sink (input valid, input word_index, input keystream_word,
		input last_word, output ready);
endinterface

FILE: src/cc20_round_stage.sv
// ---------------------------------------------------------------------------
// cc20_round_stage: one half quarter round on all four columns
// Applies either the first half (rotations 16 and 12) or the second half
// (rotations 8 and 7) of the quarter round to each column, then registers.
// ---------------------------------------------------------------------------
module cc20_round_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             late,
	input  logic             prev_vld,
	input  cc20_pkg::state_t prev_st,
	input  cc20_pkg::word_t  prev_ctr,
	output logic             vld,
	output cc20_pkg::state_t st,
	output cc20_pkg::word_t  ctr
);
	import cc20_pkg::*;

	state_t nx;
	logic   vld_s1;
	state_t st_s1;
	word_t  ctr_s1;

	always_comb begin
		word_t a, b, c, d, t;
		nx = prev_st;
		for (int q = 0; q < 4; q++) begin
			a = prev_st[q];
			b = prev_st[4 + q];
			c = prev_st[8 + q];
			d = prev_st[12 + q];
			a = a + b;
			t = d ^ a;
			d = late ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
			c = c + d;
			t = b ^ c;
			b = late ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
			nx[q]      = a;
			nx[4 + q]  = b;
			nx[8 + q]  = c;
			nx[12 + q] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= nx;
			ctr_s1 <= prev_ctr;
		end
	end

	assign vld = vld_s1;
	assign st  = st_s1;
	assign ctr = ctr_s1;

endmodule

FILE: src/cc20_serializer.sv
// ---------------------------------------------------------------------------
// cc20_serializer: block to word output buffer
// Holds one finished 16-word block and shifts it out one word per accepted
// transfer, loading the next block as the last word leaves.
// ---------------------------------------------------------------------------
module cc20_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             blk_vld,
	input  cc20_pkg::state_t blk,
	output logic             can_load,
	cc20_ks_if.source        ks
);
	import cc20_pkg::*;

	state_t buf_q;
	widx_t  idx_q;
	logic   busy_q;
	logic   load;
	logic   take;
	logic   last;

	assign last     = (idx_q == LAST_IDX);
	assign take     = busy_q && ks.ready;
	assign can_load = !busy_q || (ks.ready && last);
	assign load     = blk_vld && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= !last;
			idx_q  <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= blk;
		end else if (take) begin
			buf_q <= {32'h0, buf_q[15:1]};
		end
	end

	assign ks.valid          = busy_q;
	assign ks.word_index     = idx_q;
	assign ks.keystream_word = buf_q[0];
	assign ks.last_word      = last;

endmodule

FILE: src/chacha20_keystream_block_core.sv
// ---------------------------------------------------------------------------
// chacha20_keystream_block_core: ChaCha20 block function, pipelined
// Turns each block counter into sixteen 32-bit keystream words.
// ---------------------------------------------------------------------------
// Usage. Load the key and nonce through the configuration port (cfg_we,
// cfg_index, cfg_data) while no block is in flight; the values apply to
// every counter accepted after the write. Each word accepted on the ctr
// channel is one 32-bit block counter. The ks channel returns the sixteen
// keystream words of that block in order, word_index 0 to 15, with
// last_word set on the sixteenth.
// Pipeline: 40 round stages (four per double round), one stage that adds the
// initial state back, and the load into the output buffer, the first round
// stage being loaded at the accepting edge.
// Throughput: the round pipeline takes a counter every cycle while it is not
// stalled, but the ks channel moves at most one word per cycle, so sustained
// intake is set by the output buffer, which takes a new block only when it is
// empty or the last word of its block leaves. Up to 42 blocks may be in flight.
// Stalls: while the add stage holds a block the output buffer cannot take, the
// whole pipeline holds and ctr.ready goes low; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and the key and nonce registers to 0.
// ---------------------------------------------------------------------------
module chacha20_keystream_block_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cc20_pkg::CFG_W-1:0]     cfg_data,
	cc20_ctr_if.sink                      ctr,
	cc20_ks_if.source                     ks
);
	import cc20_pkg::*;

	// Key and nonce registers.
	logic [CFG_W-1:0] key01_q;
	logic [CFG_W-1:0] key23_q;
	logic [CFG_W-1:0] key45_q;
	logic [CFG_W-1:0] key67_q;
	logic [CFG_W-1:0] nonce01_q;
	word_t            nonce2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q   <= '0;
			key23_q   <= '0;
			key45_q   <= '0;
			key67_q   <= '0;
			nonce01_q <= '0;
			nonce2_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY01:   key01_q   <= cfg_data;
				REG_KEY23:   key23_q   <= cfg_data;
				REG_KEY45:   key45_q   <= cfg_data;
				REG_KEY67:   key67_q   <= cfg_data;
				REG_NONCE01: nonce01_q <= cfg_data;
				REG_NONCE2:  nonce2_q  <= cfg_data[31:0];
				default:     ; // Indexes beyond the register list are ignored.
			endcase
		end
	end

	// The whole pipeline moves as one: it advances whenever the add stage is
	// empty or its block goes into the output buffer in this cycle.
	logic adv;
	logic can_load;

	logic             fin_vld_s2;
	state_t           fin_st_s2;

	assign adv       = !fin_vld_s2 || can_load;
	assign ctr.ready = adv;

	// Round pipeline. Stages come in groups of four: column first half, column
	// second half, diagonal first half, diagonal second half. The diagonal
	// stages work on a row-rotated state, so the stage hardware only ever
	// processes columns; the rotation is pure wiring between stages.
	logic   stg_vld [NUM_STAGES];
	state_t stg_st  [NUM_STAGES];
	word_t  stg_ctr [NUM_STAGES];
	state_t stg_in  [NUM_STAGES];
	logic   stg_in_vld [NUM_STAGES];
	word_t  stg_in_ctr [NUM_STAGES];

	assign stg_in_vld[0] = ctr.valid;
	assign stg_in_ctr[0] = ctr.block_counter;
	assign stg_in[0]     = init_state(key01_q, key23_q, key45_q, key67_q,
		nonce01_q, nonce2_q, ctr.block_counter);

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_round
		if (k > 0) begin : g_link
			assign stg_in_vld[k] = stg_vld[k-1];
			assign stg_in_ctr[k] = stg_ctr[k-1];
			if (k % 4 == 2) begin : g_diag
				assign stg_in[k] = diagonalize(stg_st[k-1]);
			end else if (k % 4 == 0) begin : g_undiag
				assign stg_in[k] = undiagonalize(stg_st[k-1]);
			end else begin : g_plain
				assign stg_in[k] = stg_st[k-1];
			end
		end

		cc20_round_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.late     (k % 2 == 1),
			.prev_vld (stg_in_vld[k]),
			.prev_st  (stg_in[k]),
			.prev_ctr (stg_in_ctr[k]),
			.vld      (stg_vld[k]),
			.st       (stg_st[k]),
			.ctr      (stg_ctr[k])
		);
	end

	// Feed-forward stage. The initial state is rebuilt from the counter that went
	// down the pipeline with the block and from the key and nonce registers, which
	// the user must not change while a block is in flight; the core does not check.
	state_t rounds_out;
	state_t init_ff;
	state_t sum;

	assign rounds_out = undiagonalize(stg_st[NUM_STAGES-1]);
	assign init_ff    = init_state(key01_q, key23_q, key45_q, key67_q,
		nonce01_q, nonce2_q, stg_ctr[NUM_STAGES-1]);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sum[i] = rounds_out[i] + init_ff[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s2 <= 1'b0;
		end else if (adv) begin
			fin_vld_s2 <= stg_vld[NUM_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_st_s2 <= sum;
		end
	end

	// Output buffer: one block, shifted out a word at a time.
	cc20_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_vld  (fin_vld_s2),
		.blk      (fin_st_s2),
		.can_load (can_load),
		.ks       (ks)
	);

`ifndef SYNTH
	// A block, once started, streams out without gaps in its valid.
	a_block_continues: assert property (@(posedge clk) disable iff (!arst_n)
		ks.valid && ks.ready && !ks.last_word |=> ks.valid)
		else $error("keystream block interrupted before its last word");

	// Word positions count up by one within a block.
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ks.valid && ks.ready && !ks.last_word |=>
			ks.word_index == $past(ks.word_index) + 4'd1)
		else $error("keystream word index did not advance by one");

	// A finished block waiting on a full output buffer is held, not lost.
	a_fin_held: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld_s2 && !can_load |=> fin_vld_s2 && $stable(fin_st_s2))
		else $error("finished block lost while output buffer was full");

	// A counter is taken only when the pipeline moves.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld_s2 && !can_load |-> !ctr.ready)
		else $error("counter accepted while pipeline was stalled");
`endif

endmodule

FILE: tb/sv/chacha20_keystream_block_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chacha20_keystream_block_core_tb: self-checking bench for the keystream core
// Feeds block counters under several key and nonce settings, predicts the
// sixteen keystream words of every accepted counter with its own ChaCha20
// block function, and checks each word leaving the core in order.
// ---------------------------------------------------------------------------
module chacha20_keystream_block_core_tb;
	import cc20_pkg::*;

	// ChaCha20 "expand 32-byte k" constant words.
	localparam word_t EXPAND0 = 32'h61707865;
	localparam word_t EXPAND1 = 32'h3320646e;
	localparam word_t EXPAND2 = 32'h79622d32;
	localparam word_t EXPAND3 = 32'h6b206574;

	// Register indexes past the end of the map; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	// Cycles to let pass after the last word, a little above the core latency.
	localparam int DRAIN_CYCLES = 60;
	// Length of the one long stall on the keystream side.
	localparam int FLOOD_CYCLES = 600;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS = 92;

	typedef logic [15:0][31:0] ks_words_t;

	typedef struct packed {
		widx_t word_index;
		word_t keystream_word;
		logic  last_word;
	} ks_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	cc20_ctr_if ctr_ch ();
	cc20_ks_if  ks_ch ();

	chacha20_keystream_block_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctr       (ctr_ch),
		.ks        (ks_ch)
	);

	// Our own copy of the key and nonce registers, following the write port.
	logic [CFG_W-1:0] key01_sh;
	logic [CFG_W-1:0] key23_sh;
	logic [CFG_W-1:0] key45_sh;
	logic [CFG_W-1:0] key67_sh;
	logic [CFG_W-1:0] nonce01_sh;
	word_t            nonce2_sh;

	// Counters waiting to be offered, and keystream words still owed by the core.
	word_t    counter_queue[$];
	ks_word_t ks_expect_q[$];

	int n_queued = 0;
	int n_accepted = 0;
	int n_fail = 0;

	// Idle bookkeeping of the two sides.
	int ctr_gap = 0;
	int ctr_calm = 0;
	int ks_stall = 0;
	int ks_calm = 0;
	bit ks_flooded = 1'b0;

	// One ChaCha20 quarter round; the four words travel packed as {a, b, c, d}.
	function automatic logic [127:0] quarter_round(input word_t a, input word_t b,
		input word_t c, input word_t d);
		a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
		c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
		a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
		c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
		return {a, b, c, d};
	endfunction

	// Full block function: build the state, run the double rounds, add the
	// starting state back word by word.
	function automatic ks_words_t chacha_keystream(input logic [CFG_W-1:0] k01,
		input logic [CFG_W-1:0] k23, input logic [CFG_W-1:0] k45,
		input logic [CFG_W-1:0] k67, input logic [CFG_W-1:0] n01,
		input word_t n2, input word_t counter);
		ks_words_t start;
		ks_words_t s;
		start[0]  = EXPAND0;
		start[1]  = EXPAND1;
		start[2]  = EXPAND2;
		start[3]  = EXPAND3;
		start[4]  = k01[31:0];
		start[5]  = k01[63:32];
		start[6]  = k23[31:0];
		start[7]  = k23[63:32];
		start[8]  = k45[31:0];
		start[9]  = k45[63:32];
		start[10] = k67[31:0];
		start[11] = k67[63:32];
		start[12] = counter;
		start[13] = n01[31:0];
		start[14] = n01[63:32];
		start[15] = n2;
		s = start;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			// Column rounds.
			for (int c = 0; c < 4; c++) begin
				{s[c], s[4 + c], s[8 + c], s[12 + c]} =
					quarter_round(s[c], s[4 + c], s[8 + c], s[12 + c]);
			end
			// Diagonal rounds: row k is taken shifted left by k columns.
			for (int c = 0; c < 4; c++) begin
				{s[c], s[4 + (c + 1) % 4], s[8 + (c + 2) % 4], s[12 + (c + 3) % 4]} =
					quarter_round(s[c], s[4 + (c + 1) % 4], s[8 + (c + 2) % 4],
						s[12 + (c + 3) % 4]);
			end
		end
		for (int i = 0; i < 16; i++) begin
			s[i] = s[i] + start[i];
		end
		return s;
	endfunction

	// Counters lean on the extremes now and then, otherwise uniform.
	function automatic word_t rand_counter();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return word_t'($urandom_range(0, 15));
			3: return 32'hFFFF_FFFF - word_t'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic queue_counter(input word_t counter);
		counter_queue.push_back(counter);
		n_queued++;
	endtask

	// One write on the configuration port; the enable is high for one edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Every counter yields words, so once every queued counter has been taken
	// and every owed word has come back the core holds nothing.
	task automatic wait_idle();
		while (n_accepted != n_queued || ks_expect_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Register shadow. Indexes past the map fall through and change nothing,
	// and only the low half of the data reaches the third nonce word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_sh <= '0;
			key23_sh <= '0;
			key45_sh <= '0;
			key67_sh <= '0;
			nonce01_sh <= '0;
			nonce2_sh <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY01:   key01_sh <= cfg_data;
				REG_KEY23:   key23_sh <= cfg_data;
				REG_KEY45:   key45_sh <= cfg_data;
				REG_KEY67:   key67_sh <= cfg_data;
				REG_NONCE01: nonce01_sh <= cfg_data;
				REG_NONCE2:  nonce2_sh <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Counter driver. A counter word that is offered stays put until the core
	// takes it; the moment it is taken its sixteen keystream words are worked
	// out from the current key and nonce and lined up for the checker. Gaps
	// between counters are mostly short, now and then long, and from time to
	// time a run of counters goes back to back.
	always @(posedge clk or negedge arst_n) begin
		ks_words_t blk;
		int roll;
		if (!arst_n) begin
			ctr_ch.valid <= 1'b0;
			ctr_ch.block_counter <= '0;
		end else if (!ctr_ch.valid || ctr_ch.ready) begin
			if (ctr_ch.valid) begin
				blk = chacha_keystream(key01_sh, key23_sh, key45_sh, key67_sh,
					nonce01_sh, nonce2_sh, ctr_ch.block_counter);
				for (int i = 0; i < 16; i++) begin
					ks_expect_q.push_back('{widx_t'(i), blk[i], i == 15});
				end
				n_accepted++;
			end
			if (ctr_gap > 0) begin
				ctr_gap--;
				ctr_ch.valid <= 1'b0;
			end else if (counter_queue.size() != 0) begin
				ctr_ch.valid <= 1'b1;
				ctr_ch.block_counter <= counter_queue.pop_front();
				roll = $urandom_range(0, 99);
				if (ctr_calm > 0) begin
					ctr_calm--;
					ctr_gap = 0;
				end else if (roll < 2) begin
					ctr_calm = $urandom_range(10, 30);
					ctr_gap = 0;
				end else if (roll < 55) begin
					ctr_gap = 0;
				end else if (roll < 90) begin
					ctr_gap = $urandom_range(1, 3);
				end else begin
					ctr_gap = $urandom_range(8, 40);
				end
			end else begin
				ctr_ch.valid <= 1'b0;
			end
		end
	end

	// Keystream checker and ready generator. Each word taken is compared field
	// by field with the oldest word still owed. Ready drops at random for short
	// and long spells, stays high for calm stretches, and once, when a large
	// batch of counters has just been queued, stays low long enough for the
	// pipeline to fill and push back on the counter side.
	always @(posedge clk or negedge arst_n) begin
		ks_word_t want;
		int roll;
		if (!arst_n) begin
			ks_ch.ready <= 1'b0;
		end else begin
			if (ks_ch.valid && ks_ch.ready) begin
				if (ks_expect_q.size() == 0) begin
					$error("keystream word with nothing owed: word_index %0d, word %08h",
						ks_ch.word_index, ks_ch.keystream_word);
					n_fail++;
				end else begin
					want = ks_expect_q.pop_front();
					if (ks_ch.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d",
							want.word_index, ks_ch.word_index);
						n_fail++;
					end
					if (ks_ch.keystream_word !== want.keystream_word) begin
						$error("keystream_word: expected %08h, got %08h",
							want.keystream_word, ks_ch.keystream_word);
						n_fail++;
					end
					if (ks_ch.last_word !== want.last_word) begin
						$error("last_word: expected %0b, got %0b",
							want.last_word, ks_ch.last_word);
						n_fail++;
					end
				end
			end
			if (!ks_flooded && counter_queue.size() > 60) begin
				ks_flooded = 1'b1;
				ks_stall = FLOOD_CYCLES;
			end
			roll = $urandom_range(0, 99);
			if (ks_stall > 0) begin
				ks_stall--;
				ks_ch.ready <= 1'b0;
			end else if (ks_calm > 0) begin
				ks_calm--;
				ks_ch.ready <= 1'b1;
			end else if (roll == 0) begin
				ks_calm = $urandom_range(30, 120);
				ks_ch.ready <= 1'b1;
			end else if (roll < 70) begin
				ks_ch.ready <= 1'b1;
			end else if (roll < 96) begin
				ks_stall = $urandom_range(0, 2);
				ks_ch.ready <= 1'b0;
			end else begin
				ks_stall = $urandom_range(8, 40);
				ks_ch.ready <= 1'b0;
			end
		end
	end

	// Stimulus: three directed settings, then random phases that each load a
	// fresh mix of key and nonce values while the core is idle.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Key and nonce straight out of reset, all zero. The counters walk the
		// extremes, both halves of the range and alternating bit patterns.
		queue_counter(32'h0000_0000);
		queue_counter(32'hFFFF_FFFF);
		queue_counter(32'h0000_0001);
		queue_counter(32'h8000_0000);
		queue_counter(32'h7FFF_FFFF);
		queue_counter(32'hAAAA_AAAA);
		queue_counter(32'h5555_5555);
		wait_idle();

		// Everything at all ones. The third nonce word gets a full 64-bit value
		// whose upper half must be dropped, and the two indexes past the map are
		// written with junk that must not land anywhere.
		write_reg(REG_KEY01, '1);
		write_reg(REG_KEY23, '1);
		write_reg(REG_KEY45, '1);
		write_reg(REG_KEY67, '1);
		write_reg(REG_NONCE01, '1);
		write_reg(REG_NONCE2, '1);
		write_reg(REG_SPARE6, {$urandom(), $urandom()});
		write_reg(REG_SPARE7, {$urandom(), $urandom()});
		queue_counter(32'h0000_0000);
		queue_counter(32'hFFFF_FFFF);
		queue_counter(32'h0000_0001);
		wait_idle();

		// The published sample: key bytes 00..1f, nonce 00000009 0000004a
		// 00000000, packed little-endian into words.
		write_reg(REG_KEY01, 64'h0706_0504_0302_0100);
		write_reg(REG_KEY23, 64'h0f0e_0d0c_0b0a_0908);
		write_reg(REG_KEY45, 64'h1716_1514_1312_1110);
		write_reg(REG_KEY67, 64'h1f1e_1d1c_1b1a_1918);
		write_reg(REG_NONCE01, 64'h4a00_0000_0900_0000);
		write_reg(REG_NONCE2, 64'h0);
		queue_counter(32'h0000_0001);
		queue_counter(32'h0000_0000);
		wait_idle();

		// Random phases. The first reloads every register; later ones change a
		// random subset, so some settings differ from the last in one word only.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int r = REG_KEY01; r <= REG_NONCE2; r++) begin
				if (p == 0 || $urandom_range(0, 1) == 1) begin
					write_reg(CFG_IDX_W'(r), rand_reg_value());
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
					{$urandom(), $urandom()});
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				queue_counter(rand_counter());
			end
			wait_idle();
		end

		// Anything that shows up now was never asked for.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hang guard, far above the slowest legal run.
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
